[rtl/gsnc_pkg.sv]
// gsnc_pkg: shared constants, types and helpers for grid_sparse_neighbor_count.
// No dependencies.
package gsnc_pkg;

  localparam int MaxWidth  = 1024;
  localparam int AddrW     = $clog2(MaxWidth);
  localparam int RowWidthW = 11;
  localparam int LimitW    = 4;
  localparam int CountW    = 21;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 11;
  localparam int InBytesW  = 8;
  localparam int OutBytesW = 24;

  localparam logic [RowWidthW-1:0] RowWidthReset = RowWidthW'(MaxWidth);
  localparam logic [LimitW-1:0]    LimitReset    = LimitW'(3);
  localparam logic [CountW-1:0]    CountMax      = '1;
  localparam logic [8:0]           WinKeep       = 9'h0DB;

  // register index codes
  localparam logic [CfgIdxW-1:0] CfgRowWidth      = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgNeighborLimit = 1'b1;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } state_t;

  // one line buffer entry: the cell two rows up and the cell one row up
  typedef struct packed {
    logic above;
    logic cur;
  } line_t;

  // center occupied and neighbor count within limit
  function automatic logic qualifies(input logic [8:0] win, input logic [LimitW-1:0] limit);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) n = n + 4'(win[i]);
    end
    return win[4] && (n <= limit);
  endfunction

endpackage

[rtl/gsnc_line_buf.sv]
// gsnc_line_buf: two-row line buffer in one synchronous RAM, read-first,
// with write-to-read forwarding. Depends on gsnc_pkg.
module gsnc_line_buf (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [gsnc_pkg::AddrW-1:0] rd_addr,   // address to fetch for next cycle
  input  logic [gsnc_pkg::AddrW-1:0] want_addr, // address the logic needs now
  input  logic                      wr_en,
  input  logic [gsnc_pkg::AddrW-1:0] wr_addr,
  input  gsnc_pkg::line_t           wr_data,
  output gsnc_pkg::line_t           rd_data,
  output logic                      rd_ok
);

  gsnc_pkg::line_t mem [gsnc_pkg::MaxWidth];

  gsnc_pkg::line_t                 mem_q;
  logic [gsnc_pkg::AddrW-1:0]      rd_addr_q;
  logic                            rd_vld;
  logic                            wr_q;
  logic [gsnc_pkg::AddrW-1:0]      wr_addr_q;
  gsnc_pkg::line_t                 wr_data_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q     <= mem[rd_addr];
    rd_addr_q <= rd_addr;
    wr_addr_q <= wr_addr;
    wr_data_q <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      wr_q   <= 1'b0;
    end else begin
      rd_vld <= 1'b1;
      wr_q   <= wr_en;
    end
  end

  // a write in the read's cycle is newer than the read-first data
  assign rd_data = (wr_q && (wr_addr_q == rd_addr_q)) ? wr_data_q : mem_q;
  assign rd_ok   = rd_vld && (rd_addr_q == want_addr);

endmodule

[rtl/grid_sparse_neighbor_count.sv]
// grid_sparse_neighbor_count: 3x3 neighbor counter over a raster binary grid.
// Depends on gsnc_pkg and gsnc_line_buf.
//
// Channel    Dir  Handshake               Contents
// s_axis     in   tvalid/tready           tdata[0] occupied, tlast last cell of frame
// m_axis     out  tvalid/tready           tdata[20:0] qualifying count, one per frame
// cfg        in   cfg_we (no wait)        cfg_index 0 row_width, 1 neighbor_limit
//
// One cell per cycle in steady state. The line buffer RAM is fetched ahead
// for the next column, so only the first cycle after reset and a config
// write that moves the clamped column cost a refetch bubble.
// After the last cell the block drains on its own: the rest of the row plus
// one full row of empty cells, one per cycle, with s_axis_tready low. The
// result is then held in an output register; input resumes at once.
// A drain that is about to finish waits while a previous result is untaken.
// Reset is synchronous; line buffer contents survive reset and frame ends.
module grid_sparse_neighbor_count (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [gsnc_pkg::InBytesW-1:0]          s_axis_tdata,  // [0] occupied
  input  logic                                   s_axis_tlast,  // last_in_frame
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [gsnc_pkg::OutBytesW-1:0]         m_axis_tdata,  // [20:0] qualifying_count
  input  logic                                   cfg_we,
  input  logic [gsnc_pkg::CfgIdxW-1:0]           cfg_index,
  input  logic [gsnc_pkg::CfgDataW-1:0]          cfg_data
);

  // config
  logic [gsnc_pkg::RowWidthW-1:0] row_width;
  logic [gsnc_pkg::LimitW-1:0]    neighbor_limit;

  // control state
  gsnc_pkg::state_t              state, state_next;
  logic                          extra, extra_next;      // one more row wrap before done
  logic [gsnc_pkg::AddrW-1:0]    col, col_next;
  logic [1:0]                    row, row_next;          // 0, 1, 2 = two or more
  logic [8:0]                    win, win_next;
  logic [gsnc_pkg::CountW-1:0]   total, total_next;
  logic [gsnc_pkg::CountW-1:0]   out_count;

  // datapath
  logic [gsnc_pkg::AddrW-1:0]    wm1;   // clamped width minus one
  logic [gsnc_pkg::AddrW-1:0]    c;
  logic [gsnc_pkg::AddrW-1:0]    rd_addr;
  gsnc_pkg::line_t               rd_data;
  gsnc_pkg::line_t               wr_data;
  logic                          rd_ok;
  logic                          in_xfer, drain_push, push, wrap, finish, out_free;
  logic                          cell_bit, a, m, j1, j2;
  logic [8:0]                    win1, win2;
  logic [gsnc_pkg::CountW:0]     sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width      <= gsnc_pkg::RowWidthReset;
      neighbor_limit <= gsnc_pkg::LimitReset;
    end else if (cfg_we) begin
      case (cfg_index)
        gsnc_pkg::CfgRowWidth:      row_width      <= cfg_data[gsnc_pkg::RowWidthW-1:0];
        gsnc_pkg::CfgNeighborLimit: neighbor_limit <= cfg_data[gsnc_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  // width clamped to [1, MaxWidth], minus one
  always_comb begin
    if (row_width == '0) begin
      wm1 = '0;
    end else if (row_width > gsnc_pkg::RowWidthW'(gsnc_pkg::MaxWidth)) begin
      wm1 = gsnc_pkg::AddrW'(gsnc_pkg::MaxWidth - 1);
    end else begin
      wm1 = gsnc_pkg::AddrW'(row_width - gsnc_pkg::RowWidthW'(1));
    end
  end

  assign c    = (col > wm1) ? wm1 : col;
  assign wrap = (c == wm1);

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == gsnc_pkg::ST_RUN) && rd_ok;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign drain_push    = (state == gsnc_pkg::ST_DRAIN) && rd_ok &&
                         (!(wrap && !extra) || out_free);
  assign push          = in_xfer || drain_push;
  assign finish        = drain_push && wrap && !extra;

  // drain cells are empty
  assign cell_bit = in_xfer ? s_axis_tdata[0] : 1'b0;
  assign a        = (row == 2'd2) ? rd_data.above : 1'b0;
  assign m        = (row != 2'd0) ? rd_data.cur : 1'b0;

  // window: bits 2/5/8 newest column (top/middle/bottom row), center bit 4
  assign win1 = ((c == '0) ? 9'd0 : ((win >> 1) & gsnc_pkg::WinKeep)) |
                {cell_bit, 2'b00, m, 2'b00, a, 2'b00};
  assign win2 = (win1 >> 1) & gsnc_pkg::WinKeep;   // past the right edge
  assign j1   = (c != '0) && (row != 2'd0) && gsnc_pkg::qualifies(win1, neighbor_limit);
  assign j2   = wrap && (row != 2'd0) && gsnc_pkg::qualifies(win2, neighbor_limit);
  assign sum  = {1'b0, total} + (gsnc_pkg::CountW+1)'(j1) + (gsnc_pkg::CountW+1)'(j2);

  // line buffer: shift the column down one row
  assign wr_data.above = rd_data.cur;
  assign wr_data.cur   = cell_bit;
  // prefetch the column the next cell will use
  assign rd_addr = !push ? c : (wrap ? '0 : c + gsnc_pkg::AddrW'(1));

  gsnc_line_buf u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .rd_addr   (rd_addr),
    .want_addr (c),
    .wr_en     (push),
    .wr_addr   (c),
    .wr_data   (wr_data),
    .rd_data   (rd_data),
    .rd_ok     (rd_ok)
  );

  always_comb begin
    state_next = state;
    extra_next = extra;
    col_next   = col;
    row_next   = row;
    win_next   = win;
    total_next = total;
    if (push) begin
      win_next   = wrap ? win2 : win1;
      total_next = (sum > {1'b0, gsnc_pkg::CountMax}) ? gsnc_pkg::CountMax
                                                       : sum[gsnc_pkg::CountW-1:0];
      col_next   = wrap ? '0 : c + gsnc_pkg::AddrW'(1);
      if (wrap && row != 2'd2) row_next = row + 2'd1;
    end
    case (state)
      gsnc_pkg::ST_RUN: begin
        if (in_xfer && s_axis_tlast) begin
          state_next = gsnc_pkg::ST_DRAIN;
          extra_next = !wrap;   // partial row still to finish
        end
      end
      gsnc_pkg::ST_DRAIN: begin
        if (drain_push && wrap) begin
          if (extra) begin
            extra_next = 1'b0;
          end else begin
            state_next = gsnc_pkg::ST_RUN;
            col_next   = '0;
            row_next   = 2'd0;
            win_next   = '0;
            total_next = '0;
          end
        end
      end
      default: state_next = gsnc_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsnc_pkg::ST_RUN;
      extra <= 1'b0;
      col   <= '0;
      row   <= 2'd0;
      win   <= '0;
      total <= '0;
    end else begin
      state <= state_next;
      extra <= extra_next;
      col   <= col_next;
      row   <= row_next;
      win   <= win_next;
      total <= total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) out_count <= (sum > {1'b0, gsnc_pkg::CountMax}) ? gsnc_pkg::CountMax
                                                                : sum[gsnc_pkg::CountW-1:0];
  end

  assign m_axis_tdata = {(gsnc_pkg::OutBytesW-gsnc_pkg::CountW)'(0), out_count};

endmodule

[verif/testbench.sv]
// Self-checking testbench for grid_sparse_neighbor_count: streams binary grids, predicts
// each frame's qualifying count with an internal 3x3 neighbor counter and checks it.
// Depends on gsnc_pkg and the RTL of grid_sparse_neighbor_count.
`timescale 1ns / 100ps

module testbench;

  // ---------------------------------------------------------------------------
  // Run sizing
  // ---------------------------------------------------------------------------
  localparam int RandCells  = 1850;  // no new frame starts once this many cells are sent
  localparam int TallCells  = 400;   // width-1 column, a deep run of rows
  localparam int SettleCyc  = 8;     // pipeline slack before a register write
  localparam int TailCyc    = 64;    // watch for stray transfers at the end
  localparam int HoldCyc    = 500;   // long output stall
  localparam int DirRows    = 34;

  // predictor constants
  localparam int          LineCap   = 1024;
  localparam int          RowCap    = 2047;
  localparam logic [8:0]  KeepCols  = 9'h0DB;  // drop the column leaving the window
  localparam logic [8:0]  CenterBit = 9'h010;
  localparam logic [gsnc_pkg::CountW-1:0] TallyMax = '1;

  // ---------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [gsnc_pkg::InBytesW-1:0] s_axis_tdata = '0;   // [0] occupied
  logic                          s_axis_tlast = 1'b0; // last_in_frame
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [gsnc_pkg::OutBytesW-1:0] m_axis_tdata;       // [20:0] qualifying_count
  logic                          cfg_we = 1'b0;
  logic [gsnc_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [gsnc_pkg::CfgDataW-1:0] cfg_data = '0;

  grid_sparse_neighbor_count DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  logic [gsnc_pkg::CountW-1:0] pending_counts[$];  // frame totals still owed by the block
  int  mismatches     = 0;
  int  totals_checked = 0;
  int  cells_sent     = 0;
  int  src_idle_pct   = 31;  // chance per cycle that the cell source holds back
  int  dst_idle_pct   = 78;  // chance per cycle that the count sink holds back
  bit  long_hold_req  = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor: two line buffers, a 3x3 window (bits 0..2 row above, 3..5 the
  // row being judged, 6..8 row below; center is bit 4), position counters and
  // a saturating tally. The center cell is judged one column late, so each
  // row end shifts in an empty column to judge the last cell of that row.
  // ---------------------------------------------------------------------------
  logic [gsnc_pkg::CfgDataW-1:0] cfg_width;
  logic [gsnc_pkg::LimitW-1:0]   cfg_limit;
  bit                            line_up  [LineCap];
  bit                            line_mid [LineCap];
  logic [8:0]                    win;
  int unsigned                   col_pos;
  int unsigned                   row_pos;
  logic [gsnc_pkg::CountW-1:0]   tally;

  // zero and oversize widths clamp into 1..1024
  function automatic int unsigned eff_width(input logic [gsnc_pkg::CfgDataW-1:0] w);
    if (w == 0) return 1;
    if (w > LineCap) return LineCap;
    return w;
  endfunction

  function automatic void score_center();
    if (row_pos == 0 || !win[4]) return;
    if ($countones(win & ~CenterBit) <= cfg_limit && tally != TallyMax) tally = tally + 1'b1;
  endfunction

  function automatic void shift_in_cell(input bit occ);
    int unsigned w;
    int unsigned c;
    bit up;
    bit mid;
    w = eff_width(cfg_width);
    // a column at or past a freshly narrowed width ends the row
    c = (col_pos >= w) ? w - 1 : col_pos;
    up  = (row_pos >= 2) ? line_up[c] : 1'b0;
    mid = (row_pos >= 1) ? line_mid[c] : 1'b0;
    if (c == 0) win = '0;
    win = ((win >> 1) & KeepCols) | {occ, 2'b00, mid, 2'b00, up, 2'b00};
    if (c >= 1) score_center();
    line_up[c]  = line_mid[c];
    line_mid[c] = occ;
    if (c >= w - 1) begin
      win = (win >> 1) & KeepCols;
      score_center();
      col_pos = 0;
      if (row_pos < RowCap) row_pos++;  // saturates, processing unchanged
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // returns the frame total on the last cell, -1 otherwise
  function automatic int count_cell(input bit occ, input bit last);
    int unsigned w;
    int total;
    shift_in_cell(occ);
    if (!last) return -1;
    while (col_pos != 0) shift_in_cell(1'b0);  // pad a partial row
    w = eff_width(cfg_width);
    repeat (w) shift_in_cell(1'b0);            // empty row below the final one
    total   = tally;
    win     = '0;
    col_pos = 0;
    row_pos = 0;
    tally   = '0;
    return total;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // One cell transfer. want >= 0 overrides the predicted total on a frame end.
  task automatic send_cell(input bit occ, input bit last, input int want);
    int got;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= gsnc_pkg::InBytesW'(occ);
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    cells_sent++;
    got = count_cell(occ, last);
    if (got >= 0)
      pending_counts.push_back((want >= 0) ? want[gsnc_pkg::CountW-1:0]
                                           : got[gsnc_pkg::CountW-1:0]);
  endtask

  // stop offering cells, collect every owed total, let the pipeline settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic write_reg(input logic [gsnc_pkg::CfgIdxW-1:0] idx,
                           input logic [gsnc_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gsnc_pkg::CfgRowWidth:      cfg_width = val;
      gsnc_pkg::CfgNeighborLimit: cfg_limit = val[gsnc_pkg::LimitW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows: corner cases whose totals are plain from the grid
  // ---------------------------------------------------------------------------
  typedef enum logic {
    ROW_CELL,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [gsnc_pkg::CfgIdxW-1:0]  idx;
    logic [gsnc_pkg::CfgDataW-1:0] value;
    bit                            occ;
    bit                            last;
    int                            want;  // -1: take the predictor's total
  } dir_row_t;

  dir_row_t dir_rows [DirRows] = '{
    // reset width 1024, limit 3: lone corner cell, then an empty frame;
    // the first drain also fills both line buffers
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b1, 1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b0, 1'b1, 0},
    // width 0 clamps to 1; limit 0: a column of three all have neighbors
    '{ROW_REG,  gsnc_pkg::CfgRowWidth,      11'd0,    1'b0, 1'b0, -1},
    '{ROW_REG,  gsnc_pkg::CfgNeighborLimit, 11'd0,    1'b0, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b1, 0},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b1, 1},
    // limit above eight: every occupied cell counts
    '{ROW_REG,  gsnc_pkg::CfgNeighborLimit, 11'd15,   1'b0, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b1, 3},
    // full 3x3 at limit 8: center with eight neighbors still counts
    '{ROW_REG,  gsnc_pkg::CfgRowWidth,      11'd3,    1'b0, 1'b0, -1},
    '{ROW_REG,  gsnc_pkg::CfgNeighborLimit, 11'd8,    1'b0, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b1, 9},
    // width 2047 clamps to 1024; frame ends three cells into the row
    '{ROW_REG,  gsnc_pkg::CfgRowWidth,      11'd2047, 1'b0, 1'b0, -1},
    '{ROW_REG,  gsnc_pkg::CfgNeighborLimit, 11'd3,    1'b0, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b0, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b1, 2},
    // width narrowed mid-row: the next cell closes the row
    '{ROW_REG,  gsnc_pkg::CfgRowWidth,      11'd4,    1'b0, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b0, -1},
    '{ROW_REG,  gsnc_pkg::CfgRowWidth,      11'd2,    1'b0, 1'b0, -1},
    '{ROW_CELL, gsnc_pkg::CfgRowWidth,      11'd0,    1'b1, 1'b1, -1}
  };

  // ---------------------------------------------------------------------------
  // Count sink: checks each result transfer, then picks next cycle's tready.
  // A long hold is counted down here while the source keeps pushing frames.
  // ---------------------------------------------------------------------------
  int hold_left = 0;

  always @(posedge clk) begin : count_sink
    logic [gsnc_pkg::CountW-1:0] want_count;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_counts.size() == 0) begin
          mismatches++;
          $display("%0t ns: qualifying_count transfer with none expected, got %0d",
                   $time, m_axis_tdata[gsnc_pkg::CountW-1:0]);
        end else begin
          want_count = pending_counts.pop_front();
          totals_checked++;
          if (m_axis_tdata[gsnc_pkg::CountW-1:0] !== want_count) begin
            mismatches++;
            $display("%0t ns: qualifying_count mismatch: expected %0d, got %0d",
                     $time, want_count, m_axis_tdata[gsnc_pkg::CountW-1:0]);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = HoldCyc;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : cell_source
    int unsigned w;
    int unsigned n;
    int unsigned dens;
    int unsigned change_at;
    int unsigned r;
    bit          pressed;

    // predictor reset state
    cfg_width = gsnc_pkg::RowWidthReset;
    cfg_limit = gsnc_pkg::LimitReset;
    win       = '0;
    col_pos   = 0;
    row_pos   = 0;
    tally     = '0;
    foreach (line_up[i]) begin
      line_up[i]  = 1'b0;
      line_mid[i] = 1'b0;
    end
    pressed   = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_cell(dir_rows[i].occ, dir_rows[i].last, dir_rows[i].want);
      end
    end

    // Random frames: mostly narrow grids with a few rows, some full-width
    // ones that end early, registers changed between frames and now and
    // then mid-frame. Idling: source light / sink heavy, then swapped, then none.
    while (cells_sent < RandCells) begin
      if (cells_sent < RandCells / 3) begin
        src_idle_pct = 31;
        dst_idle_pct = 78;
      end else if (cells_sent < 2 * RandCells / 3) begin
        src_idle_pct = 78;
        dst_idle_pct = 31;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
        if (!pressed) begin
          pressed = 1'b1;
          // sink stalls long; back-to-back tiny frames fill the output
          // register and then hold off the next drain and the cell input
          wait_idle();
          write_reg(gsnc_pkg::CfgRowWidth, 11'd2);
          long_hold_req = 1'b1;
          repeat (8) begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) send_cell(1'($urandom_range(1)), k == n - 1, -1);
          end
          // one tall column of width-1 rows
          wait_idle();
          write_reg(gsnc_pkg::CfgRowWidth, 11'd1);
          for (int k = 0; k < TallCells; k++)
            send_cell($urandom_range(99) < 60, k == TallCells - 1, -1);
        end
      end

      r = $urandom_range(3);
      if (r != 0) begin
        wait_idle();
        if (r[0]) begin
          r = $urandom_range(99);
          if (r < 70)      w = $urandom_range(1, 8);
          else if (r < 88) w = $urandom_range(9, 40);
          else if (r < 94) w = $urandom_range(1000, 1024);
          else if (r < 97) w = 0;
          else             w = $urandom_range(1025, 2047);
          write_reg(gsnc_pkg::CfgRowWidth, gsnc_pkg::CfgDataW'(w));
        end
        if (r[1] || $urandom_range(3) == 0)
          write_reg(gsnc_pkg::CfgNeighborLimit, ($urandom_range(99) < 85) ?
                    gsnc_pkg::CfgDataW'($urandom_range(8)) :
                    gsnc_pkg::CfgDataW'($urandom_range(9, 15)));
      end

      w = eff_width(cfg_width);
      if (w <= 40) n = w * $urandom_range(1, 6) - $urandom_range(w - 1);
      else         n = $urandom_range(1, 60);
      dens      = $urandom_range(100);
      change_at = (n >= 2 && $urandom_range(7) == 0) ? $urandom_range(1, n - 1) : 0;
      for (int k = 0; k < n; k++) begin
        if (change_at != 0 && k == change_at) begin
          wait_idle();
          write_reg(gsnc_pkg::CfgRowWidth, gsnc_pkg::CfgDataW'($urandom_range(1, 12)));
        end
        send_cell($urandom_range(99) < dens, k == n - 1, -1);
      end
    end

    wait_idle();
    repeat (TailCyc) @(posedge clk);

    $display("Run covered %0d cell transfers and %0d frame totals: widths 0..2047,",
             cells_sent, totals_checked);
    $display("limits 0..15, mid-row width changes, a %0d-row column and a %0d-cycle stall.",
             TallCells, HoldCyc);
    if (mismatches == 0 && pending_counts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #80_000_000;
    $display("%0t ns: timeout, %0d totals still owed", $time, pending_counts.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/gsnc_pkg.sv
rtl/gsnc_line_buf.sv
rtl/grid_sparse_neighbor_count.sv
verif/testbench.sv
